>>> sv/rvs_pkg.sv
// Types, codes and constant descriptor tables for the regulator voltage select block.
package rvs_pkg;

  localparam int unsigned VOLT_W = 22;
  localparam int unsigned CODE_W = 7;
  localparam int unsigned WORD_W = CODE_W + 1;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned TOFF_W = 6;
  localparam int unsigned TLEN_W = 4;
  localparam int unsigned TCODE_W = 4;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned NUM_DESC = 36;

  typedef enum logic [1:0] {
    CMD_SET_EN = 2'd0,
    CMD_GET_EN = 2'd1,
    CMD_SET_V  = 2'd2,
    CMD_GET_V  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_NO_MATCH    = 3'd3,
    ST_DEVICE      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_BUCK  = 2'd0,
    K_FIXED = 2'd1,
    K_TABLE = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_SRCH,
    S_WB,
    S_FIN
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   mask;
    logic [VOLT_W-1:0]   base;
    logic [STEP_W-1:0]   step;
    logic [VOLT_W-1:0]   top;
    logic [TOFF_W-1:0]   toff;
    logic [TLEN_W-1:0]   tlen;
  } desc_t;

  typedef struct packed {
    logic [VOLT_W-1:0]  volt;
    logic [TCODE_W-1:0] code;
  } sel_t;

  function automatic desc_t bk(logic [CODE_W-1:0] m, logic [STEP_W-1:0] st,
                               logic [VOLT_W-1:0] lo, logic [VOLT_W-1:0] hi);
    desc_t d;
    d      = '0;
    d.kind = K_BUCK;
    d.mask = m;
    d.step = st;
    d.base = lo;
    d.top  = hi;
    return d;
  endfunction

  function automatic desc_t fx(logic [VOLT_W-1:0] v);
    desc_t d;
    d      = '0;
    d.kind = K_FIXED;
    d.base = v;
    return d;
  endfunction

  function automatic desc_t tb(logic [CODE_W-1:0] m, logic [TOFF_W-1:0] o,
                               logic [TLEN_W-1:0] n);
    desc_t d;
    d      = '0;
    d.kind = K_TABLE;
    d.mask = m;
    d.toff = o;
    d.tlen = n;
    return d;
  endfunction

  function automatic desc_t reg_desc(logic [5:0] idx);
    desc_t d;
    d      = '0;
    d.kind = K_NONE;
    case (idx)
      6'd0:  d = bk(7'h7f, 16'd12500, 22'd500000, 22'd2087500);
      6'd1:  d = bk(7'h7f, 16'd6250, 22'd500000, 22'd1293750);
      6'd2:  d = bk(7'h3f, 16'd50000, 22'd500000, 22'd3650000);
      6'd3:  d = bk(7'h7f, 16'd6250, 22'd500000, 22'd1293750);
      6'd4:  d = bk(7'h7f, 16'd6250, 22'd500000, 22'd1293750);
      6'd5:  d = bk(7'h7f, 16'd6250, 22'd500000, 22'd1293750);
      6'd6:  d = bk(7'h7f, 16'd12500, 22'd500000, 22'd2087500);
      6'd7:  d = bk(7'h7f, 16'd6250, 22'd500000, 22'd1293750);
      6'd8:  d = bk(7'h7f, 16'd12500, 22'd1000000, 22'd2587500);
      6'd9:  d = fx(22'd1200000);
      6'd10: d = fx(22'd1800000);
      6'd11: d = fx(22'd1800000);
      6'd12: d = fx(22'd1800000);
      6'd13: d = fx(22'd2800000);
      6'd14: d = fx(22'd2800000);
      6'd15: d = fx(22'd2200000);
      6'd16: d = fx(22'd1800000);
      6'd17: d = fx(22'd2800000);
      6'd18: d = fx(22'd2800000);
      6'd19: d = fx(22'd1200000);
      6'd20: d = fx(22'd1800000);
      6'd21: d = fx(22'd2800000);
      6'd22: d = tb(7'hf, 6'd0, 4'd2);
      6'd23: d = tb(7'hf, 6'd2, 4'd5);
      6'd24: d = tb(7'hf, 6'd7, 4'd8);
      6'd25: d = tb(7'h7, 6'd15, 4'd2);
      6'd26: d = tb(7'hf, 6'd17, 4'd7);
      6'd27: d = tb(7'hf, 6'd24, 4'd3);
      6'd28: d = tb(7'h7, 6'd27, 4'd3);
      6'd29: d = tb(7'hf, 6'd30, 4'd6);
      6'd30: d = tb(7'h7, 6'd27, 4'd3);
      6'd31: d = tb(7'h3, 6'd36, 4'd3);
      6'd32: d = tb(7'hf, 6'd30, 4'd6);
      6'd33: d = tb(7'hf, 6'd39, 4'd4);
      6'd34: d = tb(7'h3, 6'd43, 4'd2);
      6'd35: d = tb(7'hf, 6'd2, 4'd5);
      default: d.kind = K_NONE;
    endcase
    return d;
  endfunction

  function automatic sel_t sel_entry(logic [TOFF_W-1:0] i);
    sel_t e;
    e = '0;
    case (i)
      // dram2
      6'd0:  e = '{22'd600000, 4'h0};
      6'd1:  e = '{22'd1800000, 4'hC};
      // sim
      6'd2:  e = '{22'd1700000, 4'h3};
      6'd3:  e = '{22'd1800000, 4'h4};
      6'd4:  e = '{22'd2700000, 4'h8};
      6'd5:  e = '{22'd3000000, 4'hB};
      6'd6:  e = '{22'd3100000, 4'hC};
      // vibr
      6'd7:  e = '{22'd1200000, 4'h0};
      6'd8:  e = '{22'd1300000, 4'h1};
      6'd9:  e = '{22'd1500000, 4'h2};
      6'd10: e = '{22'd1800000, 4'h4};
      6'd11: e = '{22'd2000000, 4'h5};
      6'd12: e = '{22'd2800000, 4'h9};
      6'd13: e = '{22'd3000000, 4'hB};
      6'd14: e = '{22'd3300000, 4'hD};
      // usb
      6'd15: e = '{22'd3000000, 4'h3};
      6'd16: e = '{22'd3100000, 4'h4};
      // camd
      6'd17: e = '{22'd900000, 4'h3};
      6'd18: e = '{22'd1000000, 4'h4};
      6'd19: e = '{22'd1100000, 4'h5};
      6'd20: e = '{22'd1200000, 4'h6};
      6'd21: e = '{22'd1300000, 4'h7};
      6'd22: e = '{22'd1500000, 4'h9};
      6'd23: e = '{22'd1800000, 4'hC};
      // efuse
      6'd24: e = '{22'd1700000, 4'hB};
      6'd25: e = '{22'd1800000, 4'hC};
      6'd26: e = '{22'd1900000, 4'hD};
      // mch / emc
      6'd27: e = '{22'd2900000, 4'h2};
      6'd28: e = '{22'd3000000, 4'h3};
      6'd29: e = '{22'd3300000, 4'h5};
      // cama
      6'd30: e = '{22'd1800000, 4'h0};
      6'd31: e = '{22'd2500000, 4'h7};
      6'd32: e = '{22'd2700000, 4'h9};
      6'd33: e = '{22'd2800000, 4'hA};
      6'd34: e = '{22'd2900000, 4'hB};
      6'd35: e = '{22'd3000000, 4'hC};
      // cn33
      6'd36: e = '{22'd3300000, 4'h1};
      6'd37: e = '{22'd3400000, 4'h2};
      6'd38: e = '{22'd3500000, 4'h3};
      // mc
      6'd39: e = '{22'd1800000, 4'h4};
      6'd40: e = '{22'd2900000, 4'hA};
      6'd41: e = '{22'd3000000, 4'hB};
      6'd42: e = '{22'd3300000, 4'hD};
      // ldo28
      6'd43: e = '{22'd2800000, 4'h1};
      6'd44: e = '{22'd3000000, 4'h3};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

>>> sv/rvs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 35,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/regulator_voltage_select_control.sv
// Top level of the regulator bank: enable and voltage selector control per regulator.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------------
//   in      | to block  | in_valid/in_ready  | cmd, regulator_index, enable_value, voltage_in
//   out     | from block| out_valid/out_ready| status, enabled_flag, voltage_out
//
// One item is in work at a time; a new item is accepted only in the idle state.
// Enable commands, fixed LDOs, buck get voltage and invalid indices go from the execute
// state to the finish state, which loads the result register; a buck set voltage runs
// seven restoring-division steps, one quotient bit each, then a write-back; table LDO
// voltage commands scan one table entry per cycle until a hit or the last entry.
// Reset clears the per-entry valid bits at once, so an entry never written reads as
// zero; no clearing pass. A result waits in the output register while the next item
// is accepted; a stalled output holds the block only when a second result is ready.
module regulator_voltage_select_control #(
  parameter int unsigned NUM_REGULATORS = 35
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [5:0]  regulator_index,
  input  logic        enable_value,
  input  logic [21:0] voltage_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        enabled_flag,
  output logic [21:0] voltage_out
);

  localparam int unsigned AW = (NUM_REGULATORS > 1) ? $clog2(NUM_REGULATORS) : 1;

  rvs_pkg::state_t state, state_next;

  // latched item
  rvs_pkg::cmd_t                  cmd_r;
  logic [5:0]                     idx_r;
  logic                           en_r;
  logic [rvs_pkg::VOLT_W-1:0]     v_r;

  // division / search working registers
  logic [rvs_pkg::VOLT_W-1:0]     rem;
  logic [rvs_pkg::CODE_W-1:0]     quo;
  logic [rvs_pkg::CNT_W-1:0]      cnt;

  // pending result
  rvs_pkg::status_t               res_status;
  logic                           res_flag;
  logic [rvs_pkg::VOLT_W-1:0]     res_vout;

  // result as known in the first execution cycle
  rvs_pkg::status_t               exec_status;
  logic                           exec_flag;
  logic [rvs_pkg::VOLT_W-1:0]     exec_vout;

  // entry valid bits: an entry that was never written reads as zero
  logic [NUM_REGULATORS-1:0]      vld;

  logic [AW-1:0]                  ram_raddr;
  logic [AW-1:0]                  ram_waddr;
  logic                           ram_we;
  logic [rvs_pkg::WORD_W-1:0]     ram_wdata;
  logic [rvs_pkg::WORD_W-1:0]     ram_rdata;

  rvs_pkg::desc_t                 desc;
  logic                           idx_ok;
  logic                           cur_en;
  logic [rvs_pkg::CODE_W-1:0]     cur_code;
  logic [rvs_pkg::CODE_W-1:0]     code_m;
  logic [rvs_pkg::VOLT_W-1:0]     v_clamp;
  logic [rvs_pkg::VOLT_W:0]       shifted;
  logic                           div_fit;
  rvs_pkg::sel_t                  ent;
  logic                           hit;
  logic                           last_ent;
  logic [rvs_pkg::VOLT_W+1:0]     buck_v;
  logic                           out_free;
  logic                           accept;

  rvs_ram #(
    .WIDTH (rvs_pkg::WORD_W),
    .DEPTH (NUM_REGULATORS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign ram_waddr = idx_r[AW-1:0];
  // read at the incoming index on accept, then hold the address so the data stays
  assign ram_raddr = (state == rvs_pkg::S_IDLE) ? regulator_index[AW-1:0] : idx_r[AW-1:0];

  // descriptor lookup and current entry
  assign desc     = rvs_pkg::reg_desc(idx_r);
  assign idx_ok   = ({1'b0, idx_r} < 7'(NUM_REGULATORS)) && (desc.kind != rvs_pkg::K_NONE);
  assign cur_en   = vld[ram_waddr] & ram_rdata[0];
  assign cur_code = vld[ram_waddr] ? ram_rdata[rvs_pkg::WORD_W-1:1] : '0;
  assign code_m   = cur_code & desc.mask;

  // buck clamp to [min, max] and one restoring-division step
  always_comb begin
    if (v_r > desc.top) begin
      v_clamp = desc.top;
    end else if (v_r < desc.base) begin
      v_clamp = desc.base;
    end else begin
      v_clamp = v_r;
    end
  end
  assign shifted = 23'(desc.step) << cnt;
  assign div_fit = {1'b0, rem} >= shifted;

  assign buck_v = 24'(desc.base) + 24'(code_m) * 24'(desc.step);

  // table scan, one entry per cycle
  assign ent      = rvs_pkg::sel_entry(desc.toff + 6'(cnt));
  assign hit      = (cmd_r == rvs_pkg::CMD_SET_V) ? (ent.volt == v_r)
                                                  : (7'(ent.code) == code_m);
  assign last_ent = (4'(cnt) == (desc.tlen - 4'd1));

  // first-cycle result; a table scan starts from a miss and clears it on a hit
  always_comb begin
    exec_status = rvs_pkg::ST_OK;
    exec_flag   = 1'b0;
    exec_vout   = '0;
    if (!idx_ok) begin
      exec_status = rvs_pkg::ST_INVALID;
    end else begin
      case (cmd_r)
        rvs_pkg::CMD_GET_EN: begin
          exec_flag = cur_en;
        end
        rvs_pkg::CMD_SET_V: begin
          if (desc.kind == rvs_pkg::K_FIXED) begin
            exec_status = rvs_pkg::ST_UNSUPPORTED;
          end else if (desc.kind == rvs_pkg::K_TABLE) begin
            exec_status = rvs_pkg::ST_NO_MATCH;
          end
        end
        rvs_pkg::CMD_GET_V: begin
          if (desc.kind == rvs_pkg::K_FIXED) begin
            exec_vout = desc.base;
          end else if (desc.kind == rvs_pkg::K_BUCK) begin
            exec_vout = buck_v[rvs_pkg::VOLT_W-1:0];
          end else begin
            exec_status = rvs_pkg::ST_DEVICE;
          end
        end
        default: begin
          exec_flag = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rvs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = rvs_pkg::S_EXEC;
        end
      end
      rvs_pkg::S_EXEC: begin
        state_next = rvs_pkg::S_FIN;
        if (idx_ok && cmd_r == rvs_pkg::CMD_SET_V && desc.kind == rvs_pkg::K_BUCK) begin
          state_next = rvs_pkg::S_DIV;
        end else if (idx_ok && desc.kind == rvs_pkg::K_TABLE &&
                     (cmd_r == rvs_pkg::CMD_SET_V || cmd_r == rvs_pkg::CMD_GET_V)) begin
          state_next = rvs_pkg::S_SRCH;
        end
      end
      rvs_pkg::S_DIV: begin
        if (cnt == '0) begin
          state_next = rvs_pkg::S_WB;
        end
      end
      rvs_pkg::S_SRCH: begin
        if (hit) begin
          state_next = (cmd_r == rvs_pkg::CMD_SET_V) ? rvs_pkg::S_WB : rvs_pkg::S_FIN;
        end else if (last_ent) begin
          state_next = rvs_pkg::S_FIN;
        end
      end
      rvs_pkg::S_WB: begin
        state_next = rvs_pkg::S_FIN;
      end
      rvs_pkg::S_FIN: begin
        if (out_free) begin
          state_next = rvs_pkg::S_IDLE;
        end
      end
      default: state_next = rvs_pkg::S_IDLE;
    endcase
  end

  // control outputs: handshake and memory write
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = {cur_code, cur_en};
    case (state)
      rvs_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      rvs_pkg::S_EXEC: begin
        // set enable: keep the code, replace the bit
        if (idx_ok && cmd_r == rvs_pkg::CMD_SET_EN) begin
          ram_we    = 1'b1;
          ram_wdata = {cur_code, en_r};
        end
      end
      rvs_pkg::S_WB: begin
        // set voltage: keep the bit, replace the code
        ram_we    = 1'b1;
        ram_wdata = {quo & desc.mask, cur_en};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rvs_pkg::S_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (state == rvs_pkg::S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= rvs_pkg::cmd_t'(cmd);
      idx_r <= regulator_index;
      en_r  <= enable_value;
      v_r   <= voltage_in;
    end
    case (state)
      rvs_pkg::S_EXEC: begin
        res_status <= exec_status;
        res_flag   <= exec_flag;
        res_vout   <= exec_vout;
        // prime both the divider and the table scan; at most one of them runs
        rem        <= v_clamp - desc.base;
        quo        <= '0;
        cnt        <= (desc.kind == rvs_pkg::K_BUCK) ? 3'(rvs_pkg::CODE_W - 1) : '0;
      end
      rvs_pkg::S_DIV: begin
        if (div_fit) begin
          rem      <= rem - shifted[rvs_pkg::VOLT_W-1:0];
          quo[cnt] <= 1'b1;
        end
        cnt <= cnt - 3'd1;
      end
      rvs_pkg::S_SRCH: begin
        if (hit) begin
          res_status <= rvs_pkg::ST_OK;
          if (cmd_r == rvs_pkg::CMD_SET_V) begin
            quo <= 7'(ent.code) & desc.mask;
          end else begin
            res_vout <= ent.volt;
          end
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
      rvs_pkg::S_FIN: begin
        if (out_free) begin
          status       <= res_status;
          enabled_flag <= res_flag;
          voltage_out  <= res_vout;
        end
      end
      default: begin
        res_flag <= res_flag;
      end
    endcase
  end

  // no write may land on a regulator that does not exist
  a_no_write_invalid: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> idx_ok)
    else $error("store written for an invalid regulator");

  // an accepted item always goes to execution with its entry read
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == rvs_pkg::S_EXEC)
    else $error("accepted item did not enter execution");

  // the division runs only for a buck set voltage
  a_div_buck: assert property (@(posedge clk) disable iff (rst)
    state == rvs_pkg::S_DIV |-> (desc.kind == rvs_pkg::K_BUCK && cmd_r == rvs_pkg::CMD_SET_V))
    else $error("division started for a non-buck command");

  // an invalid regulator reports zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rvs_pkg::ST_INVALID) |-> (!enabled_flag && voltage_out == '0))
    else $error("invalid regulator result carries data");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the regulator voltage select control block.
module tb_top;

  localparam int unsigned NUM_REGULATORS = 35;
  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned RANDOM_ITEMS = 1400;
  // Longest command (table scan) plus output register, with margin.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TIMEOUT_NS = 4000000;

  // One reply as the block should present it.
  typedef struct packed {
    rvs_pkg::status_t st;
    logic             flag;
    logic [21:0]      volt;
  } reply_t;

  // Receiver stall patterns; each one holds for a random span of cycles.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_EVERY_FOURTH,
    RX_SPARSE,
    RX_COIN
  } rx_pattern_t;

  // Shadow copy of the regulator bank: descriptors, enable bits, selector
  // codes, and the replies still owed by the block, oldest first.
  class reg_bank_shadow;
    rvs_pkg::kind_t kind [64];
    logic [6:0]  mask [64];
    int unsigned base [64];
    int unsigned step [64];
    int unsigned top  [64];
    int unsigned toff [64];
    int unsigned tlen [64];
    int unsigned tab_volt [45];
    logic [3:0]  tab_code [45];
    logic        en_bits [64];
    logic [6:0]  codes [64];
    reply_t      expected_replies [$];
    int          mismatches;
    int          checked;

    function new();
      int unsigned buck_step [9] = '{12500, 6250, 50000, 6250, 6250, 6250, 12500, 6250, 12500};
      int unsigned buck_min [9] = '{500000, 500000, 500000, 500000, 500000, 500000, 500000,
                                    500000, 1000000};
      int unsigned buck_max [9] = '{2087500, 1293750, 3650000, 1293750, 1293750, 1293750,
                                    2087500, 1293750, 2587500};
      int unsigned fixed_v [13] = '{1200000, 1800000, 1800000, 1800000, 2800000, 2800000,
                                    2200000, 1800000, 2800000, 2800000, 1200000, 1800000,
                                    2800000};
      logic [6:0]  ldo_mask [13] = '{7'hf, 7'hf, 7'hf, 7'h7, 7'hf, 7'hf, 7'h7, 7'hf, 7'h7,
                                     7'h3, 7'hf, 7'hf, 7'h3};
      int unsigned ldo_off [13] = '{0, 2, 7, 15, 17, 24, 27, 30, 27, 36, 30, 39, 43};
      int unsigned ldo_len [13] = '{2, 5, 8, 2, 7, 3, 3, 6, 3, 3, 6, 4, 2};
      tab_volt = '{600000, 1800000,
                   1700000, 1800000, 2700000, 3000000, 3100000,
                   1200000, 1300000, 1500000, 1800000, 2000000, 2800000, 3000000, 3300000,
                   3000000, 3100000,
                   900000, 1000000, 1100000, 1200000, 1300000, 1500000, 1800000,
                   1700000, 1800000, 1900000,
                   2900000, 3000000, 3300000,
                   1800000, 2500000, 2700000, 2800000, 2900000, 3000000,
                   3300000, 3400000, 3500000,
                   1800000, 2900000, 3000000, 3300000,
                   2800000, 3000000};
      tab_code = '{4'h0, 4'hC,
                   4'h3, 4'h4, 4'h8, 4'hB, 4'hC,
                   4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h9, 4'hB, 4'hD,
                   4'h3, 4'h4,
                   4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'h9, 4'hC,
                   4'hB, 4'hC, 4'hD,
                   4'h2, 4'h3, 4'h5,
                   4'h0, 4'h7, 4'h9, 4'hA, 4'hB, 4'hC,
                   4'h1, 4'h2, 4'h3,
                   4'h4, 4'hA, 4'hB, 4'hD,
                   4'h1, 4'h3};
      for (int i = 0; i < 64; i++) begin
        kind[i] = rvs_pkg::K_NONE;
        mask[i] = '0;
        base[i] = 0;
        step[i] = 0;
        top[i] = 0;
        toff[i] = 0;
        tlen[i] = 0;
        en_bits[i] = 1'b0;
        codes[i] = '0;
      end
      // Descriptor order: nine bucks, thirteen fixed LDOs, thirteen table LDOs.
      for (int i = 0; i < 9; i++) begin
        kind[i] = rvs_pkg::K_BUCK;
        mask[i] = (i == 2) ? 7'h3f : 7'h7f;
        base[i] = buck_min[i];
        step[i] = buck_step[i];
        top[i] = buck_max[i];
      end
      for (int i = 0; i < 13; i++) begin
        kind[9 + i] = rvs_pkg::K_FIXED;
        base[9 + i] = fixed_v[i];
        kind[22 + i] = rvs_pkg::K_TABLE;
        mask[22 + i] = ldo_mask[i];
        toff[22 + i] = ldo_off[i];
        tlen[22 + i] = ldo_len[i];
      end
      mismatches = 0;
      checked = 0;
    endfunction

    // Advance the shadow state by one accepted command and queue its reply.
    function void apply_command(rvs_pkg::cmd_t c, logic [5:0] idx, logic en, logic [21:0] v);
      reply_t      r;
      int unsigned vv;
      logic [6:0]  code;
      logic        hit;
      r.st = rvs_pkg::ST_OK;
      r.flag = 1'b0;
      r.volt = '0;
      hit = 1'b0;
      if (idx >= NUM_REGULATORS || kind[idx] == rvs_pkg::K_NONE) begin
        r.st = rvs_pkg::ST_INVALID;
      end else begin
        case (c)
          rvs_pkg::CMD_SET_EN: en_bits[idx] = en;
          rvs_pkg::CMD_GET_EN: r.flag = en_bits[idx];
          rvs_pkg::CMD_SET_V: begin
            if (kind[idx] == rvs_pkg::K_FIXED) begin
              r.st = rvs_pkg::ST_UNSUPPORTED;
            end else if (kind[idx] == rvs_pkg::K_BUCK) begin
              // Clamp into the buck's range, then round down to a step.
              vv = 32'(v);
              if (vv > top[idx]) vv = top[idx];
              else if (vv < base[idx]) vv = base[idx];
              code = 7'((vv - base[idx]) / step[idx]);
              codes[idx] = code & mask[idx];
            end else begin
              // Exact match only; a miss leaves the stored code alone.
              r.st = rvs_pkg::ST_NO_MATCH;
              for (int k = 0; k < tlen[idx] && !hit; k++) begin
                if (tab_volt[toff[idx] + k] == v) begin
                  codes[idx] = {3'b000, tab_code[toff[idx] + k]} & mask[idx];
                  r.st = rvs_pkg::ST_OK;
                  hit = 1'b1;
                end
              end
            end
          end
          default: begin
            code = codes[idx] & mask[idx];
            if (kind[idx] == rvs_pkg::K_FIXED) begin
              r.volt = 22'(base[idx]);
            end else if (kind[idx] == rvs_pkg::K_BUCK) begin
              r.volt = 22'(base[idx] + code * step[idx]);
            end else begin
              // First table entry carrying the stored code wins.
              r.st = rvs_pkg::ST_DEVICE;
              for (int k = 0; k < tlen[idx] && !hit; k++) begin
                if ({3'b000, tab_code[toff[idx] + k]} == code) begin
                  r.volt = 22'(tab_volt[toff[idx] + k]);
                  r.st = rvs_pkg::ST_OK;
                  hit = 1'b1;
                end
              end
            end
          end
        endcase
      end
      expected_replies.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch on reply %0d: %s", $realtime, checked, what);
      mismatches++;
    endtask

    // Compare one accepted reply against the oldest one owed.
    task check_reply(logic [2:0] st, logic fl, logic [21:0] vo);
      reply_t exp;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply with none pending (status %0d)", st));
      end else begin
        exp = expected_replies.pop_front();
        if (st !== exp.st)
          report($sformatf("status got %0d want %0d", st, exp.st));
        if (fl !== exp.flag)
          report($sformatf("enabled_flag got %0b want %0b", fl, exp.flag));
        if (vo !== exp.volt)
          report($sformatf("voltage_out got %0d want %0d", vo, exp.volt));
      end
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [5:0]  regulator_index;
  logic        enable_value;
  logic [21:0] voltage_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic        enabled_flag;
  logic [21:0] voltage_out;

  reg_bank_shadow shadow;

  regulator_voltage_select_control #(
    .NUM_REGULATORS(NUM_REGULATORS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .regulator_index(regulator_index),
    .enable_value(enable_value),
    .voltage_in(voltage_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .enabled_flag(enabled_flag),
    .voltage_out(voltage_out)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Present one item at the current falling edge, hold it until the block
  // takes it, note it in the shadow, and return at the next falling edge.
  task automatic issue_command(rvs_pkg::cmd_t c, logic [5:0] idx, logic en, logic [21:0] v);
    cmd = c;
    regulator_index = idx;
    enable_value = en;
    voltage_in = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    shadow.apply_command(c, idx, en, v);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed reply has come back.
  task automatic drain_replies();
    in_valid = 1'b0;
    while (shadow.expected_replies.size() != 0) @(negedge clk);
  endtask

  // Voltage for a random set: mostly values that mean something for the
  // chosen regulator, the rest full-width noise.
  function automatic logic [21:0] pick_voltage(logic [5:0] idx);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20 || idx >= NUM_REGULATORS) return 22'($urandom);
    case (shadow.kind[idx])
      rvs_pkg::K_TABLE: begin
        if (roll < 35) return 22'(shadow.tab_volt[$urandom_range(0, 44)]);
        return 22'(shadow.tab_volt[shadow.toff[idx] + $urandom_range(0, shadow.tlen[idx] - 1)]);
      end
      rvs_pkg::K_BUCK: begin
        if (roll < 55) return 22'(shadow.base[idx] + $urandom_range(0, 127) * shadow.step[idx]);
        return 22'($urandom_range(shadow.base[idx] - 200000, shadow.top[idx] + 200000));
      end
      default: return 22'($urandom_range(0, 4000000));
    endcase
  endfunction

  // Extremes of every field and each corner of the command set.
  task automatic directed_commands();
    issue_command(rvs_pkg::CMD_GET_V, 6'd22, 1'b0, 22'd0);       // table LDO, code 0 in table
    issue_command(rvs_pkg::CMD_GET_V, 6'd23, 1'b0, 22'd0);       // code 0 missing: device error
    issue_command(rvs_pkg::CMD_GET_EN, 6'd0, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_EN, 6'd0, 1'b1, 22'd0);
    issue_command(rvs_pkg::CMD_GET_EN, 6'd0, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd0, 1'b0, 22'd0);        // clamp to minimum
    issue_command(rvs_pkg::CMD_GET_V, 6'd0, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd0, 1'b1, 22'h3fffff);   // clamp to maximum
    issue_command(rvs_pkg::CMD_GET_V, 6'd0, 1'b0, 22'h3fffff);
    issue_command(rvs_pkg::CMD_SET_V, 6'd2, 1'b0, 22'd3650000);  // narrow selector at top
    issue_command(rvs_pkg::CMD_GET_V, 6'd2, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd8, 1'b0, 22'd1234567);  // rounds down to a step
    issue_command(rvs_pkg::CMD_GET_V, 6'd8, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd9, 1'b0, 22'd1200000);  // fixed LDO: unsupported
    issue_command(rvs_pkg::CMD_GET_V, 6'd21, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd24, 1'b0, 22'd3300000);
    issue_command(rvs_pkg::CMD_GET_V, 6'd24, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd24, 1'b0, 22'd3300001); // table miss
    issue_command(rvs_pkg::CMD_SET_V, 6'd34, 1'b1, 22'd3000000); // last reachable regulator
    issue_command(rvs_pkg::CMD_GET_V, 6'd34, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_SET_V, 6'd31, 1'b0, 22'd3500000);
    issue_command(rvs_pkg::CMD_GET_V, 6'd31, 1'b0, 22'd0);
    issue_command(rvs_pkg::CMD_GET_V, 6'd35, 1'b0, 22'd0);       // first invalid index
    issue_command(rvs_pkg::CMD_SET_EN, 6'd63, 1'b1, 22'h3fffff); // highest invalid index
    issue_command(rvs_pkg::CMD_GET_EN, 6'd34, 1'b1, 22'd0);
  endtask

  // Random commands in bursts of random length separated by random gaps;
  // pause once in the middle until the block has nothing owed.
  task automatic random_commands(int unsigned count);
    int unsigned burst_left;
    int unsigned gap;
    logic [5:0]  idx;
    burst_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) drain_replies();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      if ($urandom_range(0, 99) < 85) idx = 6'($urandom_range(0, NUM_REGULATORS - 1));
      else idx = 6'($urandom_range(NUM_REGULATORS, 63));
      issue_command(rvs_pkg::cmd_t'($urandom_range(0, 3)), idx, 1'($urandom_range(0, 1)),
                    pick_voltage(idx));
    end
  endtask

  // Receiver: take replies at the rising edge whenever both sides agree.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.check_reply(status, enabled_flag, voltage_out);
  end

  // Receiver stall pattern, switched every random span of cycles.
  initial begin
    rx_pattern_t pattern;
    int unsigned span;
    int unsigned tick;
    out_ready = 1'b0;
    tick = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      pattern = rx_pattern_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        case (pattern)
          RX_STEADY:       out_ready = 1'b1;
          RX_EVERY_FOURTH: out_ready = (tick % 4) != 3;
          RX_SPARSE:       out_ready = (tick % 7) < 2;
          default:         out_ready = 1'($urandom_range(0, 1));
        endcase
        tick++;
        @(negedge clk);
      end
    end
  end

  initial begin
    shadow = new();
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = rvs_pkg::CMD_GET_EN;
    regulator_index = '0;
    enable_value = 1'b0;
    voltage_in = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_commands();
    drain_replies();
    random_commands(RANDOM_ITEMS);
    drain_replies();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (shadow.mismatches == 0)
      $display("regulator_voltage_select_control regression: pass");
    else
      $display("regulator_voltage_select_control regression: fail");
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #TIMEOUT_NS;
    $display("regulator_voltage_select_control regression: fail");
    $finish;
  end

endmodule
